>>> src/mhtq_pkg.sv
// Shared types and constants for the min-heap timer queue.
// No dependencies; imported by the core and the testbench.
`default_nettype none
package mhtq_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W = 6;
    localparam int MAX_OUT = 64;
    localparam int N_W = 7;

    localparam int DEF_HEAP_DEPTH = 64;
    localparam int DEF_TIMER_COUNT = 64;

    localparam logic [1:0] FUNC_REGISTER = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    typedef struct packed {
        logic [1:0]        func;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] time_value;
    } in_req_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } out_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   owner;
    } heap_entry_t;

endpackage
`default_nettype wire

>>> src/mhtq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module mhtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/min_heap_timer_queue_core.sv
// Timer queue as a binary min-heap; one request at a time, in_ready low until it is done.
// Register writes the deadline and sifts the new entry up past each later parent; cancel
// only clears the armed bit. Tick pops stale top entries, emits and pops each due one,
// sifting the last entry down from the root, and flushes the final result; stalls hold it.
// Reset clears the count, the current time and every armed bit; heap and
// deadline memories are not cleared, since no unwritten entry's value is ever used.
`default_nettype none
module min_heap_timer_queue_core #(
    parameter int HEAP_DEPTH = mhtq_pkg::DEF_HEAP_DEPTH,
    parameter int TIMER_COUNT = mhtq_pkg::DEF_TIMER_COUNT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire mhtq_pkg::in_req_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mhtq_pkg::out_req_t    out_data
);
    import mhtq_pkg::*;

    localparam int HA = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int IW = HA + 2;
    localparam int TA = $clog2(TIMER_COUNT);
    localparam int EW = TIME_W + ID_W;

    typedef enum logic [3:0] {
        S_IDLE, S_UP, S_UP_CMP, S_TOP, S_AD, S_CHK, S_EMIT,
        S_POP, S_LAST, S_DOWN, S_LEFT, S_RIGHT, S_CMP, S_FLUSH
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;
    logic [TIME_W-1:0] cur_time_reg;
    logic [TIMER_COUNT-1:0] armed_reg;
    logic [HA-1:0]     idx_reg;
    logic [HA-1:0]     parent_reg;
    logic [HA-1:0]     child_reg;
    heap_entry_t       new_reg;      // entry being sifted up or down
    heap_entry_t       top_reg;
    heap_entry_t       cdat_reg;
    logic [N_W-1:0]    n_reg;
    out_req_t          pend_reg;     // held until we know whether it is last
    logic              pend_valid_reg;
    out_req_t          out_reg;
    logic              out_valid_reg;

    // Heap memory and per-timer deadline memory.
    logic        heap_we;
    logic [HA-1:0] heap_waddr, heap_raddr;
    heap_entry_t heap_wdata, heap_rdata;
    logic [EW-1:0] heap_rbits;
    logic        ad_we;
    logic [TA-1:0] ad_waddr, ad_raddr;
    logic [TIME_W-1:0] ad_wdata, ad_rdata;

    mhtq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rbits)
    );
    assign heap_rdata = heap_entry_t'(heap_rbits);

    mhtq_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_COUNT)) u_deadline (
        .clk(clk), .we(ad_we), .waddr(ad_waddr), .wdata(ad_wdata),
        .raddr(ad_raddr), .rdata(ad_rdata)
    );

    logic            accept;
    logic            id_ok;
    logic            heap_full;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] new_dl;
    logic [IW-1:0]   left_idx, right_idx, count_ext;
    logic            out_free;
    logic            out_load;
    logic            top_live;
    logic [TA-1:0]   in_idx, top_idx;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_free = !out_valid_reg || out_ready;
    // The pending request moves into the output register in this cycle.
    assign out_load = pend_valid_reg && out_free &&
                      ((state_reg == S_EMIT) || (state_reg == S_FLUSH));

    assign id_ok = ({26'd0, in_data.timer_id} < 32'(TIMER_COUNT));
    assign heap_full = ({{(32 - CW){1'b0}}, count_reg} >= 32'(HEAP_DEPTH));
    assign sum = {1'b0, cur_time_reg} + {1'b0, in_data.time_value};
    // Deadlines saturate instead of wrapping.
    assign new_dl = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    assign in_idx = TA'(in_data.timer_id);
    assign top_idx = TA'(top_reg.owner);

    assign left_idx = (IW'(idx_reg) << 1) + IW'(1);
    assign right_idx = left_idx + IW'(1);
    assign count_ext = IW'(count_reg);

    // A top entry is live only if its owner is still armed for this deadline.
    assign top_live = ({26'd0, top_reg.owner} < 32'(TIMER_COUNT)) &&
                      armed_reg[top_idx] && (ad_rdata == top_reg.deadline);

    always_comb
    begin
        heap_we = 1'b0;
        heap_waddr = idx_reg;
        heap_wdata = new_reg;
        heap_raddr = '0;
        ad_we = 1'b0;
        ad_waddr = in_idx;
        ad_wdata = new_dl;
        ad_raddr = TA'(heap_rdata.owner);
        case (state_reg)
            S_IDLE:
            begin
                ad_we = accept && (in_data.func == FUNC_REGISTER) && id_ok &&
                        !heap_full;
            end
            S_UP:
            begin
                heap_raddr = HA'((idx_reg - HA'(1)) >> 1);
                heap_we = (idx_reg == '0);
            end
            S_UP_CMP:
            begin
                heap_we = 1'b1;
                if (new_reg.deadline < heap_rdata.deadline)
                begin
                    heap_wdata = heap_rdata;
                end
            end
            S_POP:
            begin
                heap_raddr = HA'(count_reg - CW'(1));
            end
            S_DOWN:
            begin
                heap_raddr = HA'(left_idx);
                heap_we = (left_idx >= count_ext);
            end
            S_LEFT:
            begin
                heap_raddr = HA'(right_idx);
            end
            S_CMP:
            begin
                heap_we = 1'b1;
                if (cdat_reg.deadline < new_reg.deadline)
                begin
                    heap_wdata = cdat_reg;
                end
            end
            default:
            begin
                heap_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cur_time_reg <= '0;
            armed_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            n_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.func)
                            FUNC_REGISTER:
                            begin
                                if (id_ok && heap_full)
                                begin
                                    pend_reg <= '{kind: KIND_REFUSED,
                                        expired_id: in_data.timer_id, last: 1'b1};
                                    pend_valid_reg <= 1'b1;
                                    state_reg <= S_FLUSH;
                                end
                                else if (id_ok)
                                begin
                                    armed_reg[in_idx] <= 1'b1;
                                    new_reg <= '{deadline: new_dl,
                                        owner: in_data.timer_id};
                                    idx_reg <= HA'(count_reg);
                                    count_reg <= count_reg + CW'(1);
                                    state_reg <= S_UP;
                                end
                            end
                            FUNC_CANCEL:
                            begin
                                if (id_ok)
                                begin
                                    armed_reg[in_idx] <= 1'b0;
                                end
                            end
                            FUNC_TICK:
                            begin
                                cur_time_reg <= in_data.time_value;
                                n_reg <= '0;
                                state_reg <= S_TOP;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_UP:
                begin
                    parent_reg <= HA'((idx_reg - HA'(1)) >> 1);
                    state_reg <= (idx_reg == '0) ? S_IDLE : S_UP_CMP;
                end
                S_UP_CMP:
                begin
                    if (new_reg.deadline < heap_rdata.deadline)
                    begin
                        idx_reg <= parent_reg;
                        state_reg <= S_UP;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_TOP:
                begin
                    state_reg <= (count_reg == '0) ? S_FLUSH : S_AD;
                end
                S_AD:
                begin
                    top_reg <= heap_rdata;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (!top_live)
                    begin
                        state_reg <= S_POP;
                    end
                    else if ((top_reg.deadline > cur_time_reg) ||
                             (n_reg == N_W'(MAX_OUT)))
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        armed_reg[top_idx] <= 1'b0;
                        n_reg <= n_reg + N_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_reg <= pend_reg;
                        end
                        pend_reg <= '{kind: KIND_EXPIRED,
                            expired_id: top_reg.owner, last: 1'b0};
                        pend_valid_reg <= 1'b1;
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    count_reg <= count_reg - CW'(1);
                    idx_reg <= '0;
                    state_reg <= (count_reg == CW'(1)) ? S_TOP : S_LAST;
                end
                S_LAST:
                begin
                    new_reg <= heap_rdata;
                    state_reg <= S_DOWN;
                end
                S_DOWN:
                begin
                    child_reg <= HA'(left_idx);
                    state_reg <= (left_idx >= count_ext) ? S_TOP : S_LEFT;
                end
                S_LEFT:
                begin
                    cdat_reg <= heap_rdata;
                    state_reg <= (right_idx < count_ext) ? S_RIGHT : S_CMP;
                end
                S_RIGHT:
                begin
                    if (heap_rdata.deadline < cdat_reg.deadline)
                    begin
                        cdat_reg <= heap_rdata;
                        child_reg <= HA'(right_idx);
                    end
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (cdat_reg.deadline < new_reg.deadline)
                    begin
                        idx_reg <= child_reg;
                        state_reg <= S_DOWN;
                    end
                    else
                    begin
                        state_reg <= S_TOP;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg <= '{kind: pend_reg.kind,
                            expired_id: pend_reg.expired_id, last: 1'b1};
                        pend_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("pending request left behind at idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(32 - CW){1'b0}}, count_reg} <= 32'(HEAP_DEPTH))
        else $error("heap count beyond depth");
    a_refused_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.kind == KIND_REFUSED) |-> out_data.last)
        else $error("refused request not marked last");
`endif

endmodule
`default_nettype wire

>>> test/min_heap_timer_queue_core_tb.sv
// Self-checking bench for the min-heap timer queue: register, cancel and tick requests.
// It compares every result with an in-bench heap predictor. Depends on mhtq_pkg and
// min_heap_timer_queue_core.
`timescale 1ns / 100ps
module min_heap_timer_queue_core_tb;
    import mhtq_pkg::*;

    localparam int DEPTH = 64;
    localparam int TIMERS = 64;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_req_t out_data;

    always #1 clk = ~clk;

    min_heap_timer_queue_core #(.HEAP_DEPTH(DEPTH), .TIMER_COUNT(TIMERS)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data)
    );

    // The predictor keeps its own copy of the heap, the armed table and the clock.
    heap_entry_t shadow_heap [DEPTH];
    int shadow_count;
    bit shadow_armed [TIMERS];
    logic [47:0] shadow_deadline [TIMERS];
    logic [47:0] shadow_now;

    out_req_t pending_results [$];
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int refusals_seen = 0;

    function automatic void heap_swap(int a, int b);
        heap_entry_t t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void heap_insert(logic [47:0] dl, logic [5:0] id);
        int i;
        int p;
        i = shadow_count;
        shadow_heap[i].deadline = dl;
        shadow_heap[i].owner = id;
        shadow_count++;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (shadow_heap[i].deadline < shadow_heap[p].deadline)
            begin
                heap_swap(i, p);
                i = p;
            end
            else
                break;
        end
    endfunction

    function automatic void heap_remove_top();
        int i;
        int l;
        int c;
        i = 0;
        shadow_count--;
        if (shadow_count == 0)
            return;
        shadow_heap[0] = shadow_heap[shadow_count];
        forever
        begin
            l = 2 * i + 1;
            if (l >= shadow_count)
                break;
            c = l;
            if (l + 1 < shadow_count &&
                shadow_heap[l + 1].deadline < shadow_heap[l].deadline)
                c = l + 1;
            if (shadow_heap[c].deadline < shadow_heap[i].deadline)
            begin
                heap_swap(i, c);
                i = c;
            end
            else
                break;
        end
    endfunction

    // Works out the results of one accepted request and queues them.
    function automatic void predict_request(in_req_t rq);
        logic [48:0] sum;
        logic [47:0] dl;
        logic [5:0] own;
        out_req_t r;
        int n;
        int first;
        n = 0;
        first = pending_results.size();
        case (rq.func)
            FUNC_REGISTER:
            begin
                if (shadow_count >= DEPTH)
                begin
                    r.kind = KIND_REFUSED;
                    r.expired_id = rq.timer_id;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
                else
                begin
                    sum = {1'b0, shadow_now} + {1'b0, rq.time_value};
                    dl = sum[48] ? TMAX : sum[47:0];
                    shadow_armed[rq.timer_id] = 1'b1;
                    shadow_deadline[rq.timer_id] = dl;
                    heap_insert(dl, rq.timer_id);
                end
            end
            FUNC_CANCEL: shadow_armed[rq.timer_id] = 1'b0;
            FUNC_TICK:
            begin
                shadow_now = rq.time_value;
                while (shadow_count > 0)
                begin
                    dl = shadow_heap[0].deadline;
                    own = shadow_heap[0].owner;
                    // Cancelled or superseded entries vanish whatever the tick time.
                    if (!(shadow_armed[own] && shadow_deadline[own] == dl))
                    begin
                        heap_remove_top();
                        continue;
                    end
                    if (dl > rq.time_value || n >= MAX_OUT)
                        break;
                    heap_remove_top();
                    shadow_armed[own] = 1'b0;
                    r.kind = KIND_EXPIRED;
                    r.expired_id = own;
                    r.last = 1'b0;
                    pending_results.push_back(r);
                    n++;
                end
                if (n > 0)
                    pending_results[first + n - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Directed table; a row with has_fixed set also names its single result.
    typedef struct {
        in_req_t rq;
        bit has_fixed;
        out_req_t fixed;
    } stim_row_t;
    stim_row_t directed [$];

    function automatic stim_row_t mk(logic [1:0] f, logic [5:0] id, logic [47:0] tv);
        stim_row_t s;
        s.rq.func = f;
        s.rq.timer_id = id;
        s.rq.time_value = tv;
        s.has_fixed = 1'b0;
        s.fixed = '0;
        return s;
    endfunction

    function automatic stim_row_t mk_fixed(logic [1:0] f, logic [5:0] id, logic [47:0] tv,
                                           logic k, logic [5:0] eid);
        stim_row_t s;
        s = mk(f, id, tv);
        s.has_fixed = 1'b1;
        s.fixed.kind = k;
        s.fixed.expired_id = eid;
        s.fixed.last = 1'b1;
        return s;
    endfunction

    // Sender: holds the request until accepted; bursts with random gaps.
    int burst_left = 0;
    task automatic send_request(in_req_t rq);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= rq;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(rq);
        requests_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Receiver stalls on a pattern of its own: a slowly drifting mode.
    int stall_mode = 0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Result checker against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.kind == KIND_REFUSED)
                refusals_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d id=%0d last=%0d", $time,
                         out_data.kind, out_data.expired_id, out_data.last);
                errors++;
            end
            else
            begin
                if (out_data.kind != pending_results[0].kind)
                begin
                    $display("%0t: kind expected %0d actual %0d", $time,
                             pending_results[0].kind, out_data.kind);
                    errors++;
                end
                if (out_data.expired_id != pending_results[0].expired_id)
                begin
                    $display("%0t: expired_id expected %0d actual %0d", $time,
                             pending_results[0].expired_id, out_data.expired_id);
                    errors++;
                end
                if (out_data.last != pending_results[0].last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             pending_results[0].last, out_data.last);
                    errors++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        in_req_t rq;
        int pick;
        int k;
        logic [47:0] base;
        shadow_count = 0;
        shadow_now = '0;
        for (int i = 0; i < TIMERS; i++)
        begin
            shadow_armed[i] = 1'b0;
            shadow_deadline[i] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick on an empty heap, extremes, stale and cancelled entries, duplicates.
        directed.push_back(mk(FUNC_TICK, 6'd0, 48'd0));
        directed.push_back(mk(FUNC_REGISTER, 6'd0, 48'd0));
        directed.push_back(mk_fixed(FUNC_TICK, 6'd0, 48'd0, KIND_EXPIRED, 6'd0));
        directed.push_back(mk(FUNC_REGISTER, 6'd63, TMAX));
        directed.push_back(mk(FUNC_TICK, 6'd63, 48'd1000));
        directed.push_back(mk(FUNC_REGISTER, 6'd5, 48'd10));
        directed.push_back(mk(FUNC_CANCEL, 6'd5, 48'd0));
        directed.push_back(mk(FUNC_REGISTER, 6'd7, 48'd20));
        directed.push_back(mk(FUNC_REGISTER, 6'd7, 48'd30));
        directed.push_back(mk(FUNC_REGISTER, 6'd9, 48'd25));
        directed.push_back(mk(FUNC_REGISTER, 6'd9, 48'd25));
        directed.push_back(mk(FUNC_UNUSED, 6'd42, TMAX));
        directed.push_back(mk(FUNC_TICK, 6'd0, 48'd1100));
        directed.push_back(mk(FUNC_REGISTER, 6'd1, TMAX));
        directed.push_back(mk(FUNC_TICK, 6'd0, 48'd50));
        directed.push_back(mk(FUNC_CANCEL, 6'd63, TMAX));
        directed.push_back(mk(FUNC_TICK, 6'd0, TMAX));
        foreach (directed[i])
        begin
            send_request(directed[i].rq);
            if (directed[i].has_fixed && (pending_results.size() == 0 ||
                pending_results[pending_results.size() - 1] != directed[i].fixed))
            begin
                $display("%0t: table row %0d disagrees with predictor", $time, i);
                errors++;
            end
        end
        wait_drained();

        // Bring time back to zero, fill the heap to overflow, then drain it with ticks.
        rq.func = FUNC_TICK;
        rq.timer_id = 6'd0;
        rq.time_value = '0;
        send_request(rq);
        base = shadow_now;
        for (int i = 0; i < DEPTH + 3; i++)
        begin
            rq.func = FUNC_REGISTER;
            rq.timer_id = i[5:0];
            rq.time_value = 48'($urandom_range(0, 3));
            send_request(rq);
        end
        rq.func = FUNC_TICK;
        rq.timer_id = 6'($urandom);
        rq.time_value = base + 48'd10;
        send_request(rq);
        send_request(rq);
        wait_drained();

        // Random phase, mostly registers and ticks moving time forward.
        k = 0;
        while (k < 160)
        begin
            pick = $urandom_range(0, 99);
            rq.timer_id = 6'($urandom);
            if (pick < 50)
            begin
                rq.func = FUNC_REGISTER;
                rq.time_value = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom}) :
                                48'($urandom_range(0, 200));
            end
            else if (pick < 62)
            begin
                rq.func = FUNC_CANCEL;
                rq.time_value = 48'({$urandom, $urandom});
            end
            else if (pick < 96)
            begin
                rq.func = FUNC_TICK;
                if ($urandom_range(0, 19) == 0)
                    rq.time_value = 48'({$urandom, $urandom});
                else if ($urandom_range(0, 9) == 0)
                    rq.time_value = shadow_now - 48'($urandom_range(0, 50));
                else
                    rq.time_value = shadow_now + 48'($urandom_range(0, 120));
            end
            else
            begin
                rq.func = FUNC_UNUSED;
                rq.time_value = 48'({$urandom, $urandom});
            end
            send_request(rq);
            if (rq.func != FUNC_UNUSED)
                k++;
            if (k == 120)
                wait_drained();
        end
        wait_drained();

        $display("Sent %0d requests; checked %0d results, %0d of them refusals.",
                 requests_sent, results_seen, refusals_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

>>> filelist.f
src/mhtq_pkg.sv
src/mhtq_ram.sv
src/min_heap_timer_queue_core.sv
test/min_heap_timer_queue_core_tb.sv
